// ----- rtl/gdpr_pkg.sv -----
package gdpr_pkg;

  // grid limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 4096;

  // field and counter widths
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int GW_W       = 7;
  localparam int GH_W       = 13;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // cell kind codes
  localparam logic [KIND_W-1:0] CELL_FREE  = 2'd0;
  localparam logic [KIND_W-1:0] CELL_ROCK  = 2'd1;
  localparam logic [KIND_W-1:0] CELL_START = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

endpackage

// ----- rtl/gdpr_if.sv -----
// cell item channel
interface gdpr_cell_if;
  import gdpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] cell_kind;
  modport source (output valid, output cell_kind, input ready);
  modport sink   (input valid, input cell_kind, output ready);
endinterface

// result item channel
interface gdpr_result_if;
  logic valid;
  logic ready;
  logic path_found;
  modport source (output valid, output path_found, input ready);
  modport sink   (input valid, input path_found, output ready);
endinterface

// register write channel
interface gdpr_cfg_if;
  import gdpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/grid_downward_path_reachability.sv -----
// Streams a grid one cell item per cycle in row-major order and answers, one
// result item after the last cell, whether a downward path (down, down-left or
// down-right, diagonals needing the side cell of the source row free) leads from
// the top-row start mark to the bottom row. Sustained rate is one cell per clock;
// each cell passes through two steps: the synchronous read of the previous-row
// reach and free line memories, then the combine and write back.
// Same-entry overlap between the write of one cell and the read for the next is
// forwarded. The pipeline stalls only when a finished result is still waiting on
// the output. Width and height registers may be written between cells; the line
// memories need no clearing, as the top row's reach is derived from the start
// mark rather than stored.
module grid_downward_path_reachability (
  input  logic clk,
  input  logic rst_n,
  gdpr_cell_if.sink     in_ch,
  gdpr_result_if.source out_ch,
  gdpr_cfg_if.sink      cfg_ch
);
  import gdpr_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             is_free;
    logic             row0;
    logic             col0;
    logic             right_ok;
    logic             grid_end;
    logic             start_seen;
  } stage_t;

  // line memories
  logic reach_mem [MAX_WIDTH];
  logic free_mem  [MAX_WIDTH];

  // configuration
  logic [GW_W-1:0] grid_width_r;
  logic [GH_W-1:0] grid_height_r;

  // position and start mark
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] start_col_r;
  logic             start_seen_r;

  // read data captured at accept
  logic rd_old_r;
  logic rd_right_r;
  logic rd_free_r;

  // combine stage
  logic   s2_valid_r;
  stage_t s2_r;
  logic   held_left_r;
  logic   row_any_r;

  // output register
  logic out_valid_r;
  logic out_path_r;

  logic [GW_W-1:0]  w_eff;
  logic [GH_W-1:0]  h_eff;
  logic [GW_W-1:0]  col_inc;
  logic [GH_W-1:0]  row_inc;
  logic [COL_W-1:0] col_nxt;
  logic             last_col;
  logic             last_row;
  logic             row0;
  logic             row1;
  logic             is_free;
  logic             is_start;
  logic             advance;
  logic             in_fire;
  logic             s2_go;
  logic             left;
  logic             right;
  logic             nr;
  logic             any_nxt;
  logic             result;
  logic             fwd_reach_old;
  logic             fwd_reach_right;
  logic             fwd_free;

  // clamp dimensions
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = GW_W'(1);
    end else if (grid_width_r > GW_W'(MAX_WIDTH)) begin
      w_eff = GW_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r == '0) begin
      h_eff = GH_W'(1);
    end else if (grid_height_r > GH_W'(MAX_HEIGHT)) begin
      h_eff = GH_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
  end

  // position decode for the item at the input
  assign col_inc  = {1'b0, col_r} + GW_W'(1);
  assign row_inc  = {1'b0, row_r} + GH_W'(1);
  assign col_nxt  = col_r + COL_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);
  assign row0     = (row_r == '0);
  assign row1     = (row_r == ROW_W'(1));
  assign is_free  = (in_ch.cell_kind != CELL_ROCK);
  assign is_start = (in_ch.cell_kind == CELL_START);

  // handshake
  assign advance      = !(s2_valid_r && s2_r.grid_end && out_valid_r && !out_ch.ready);
  assign in_ch.ready  = advance;
  assign in_fire      = in_ch.valid && advance;
  assign s2_go        = s2_valid_r && advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_found = out_path_r;

  // combine previous-row reach with this cell
  always_comb begin
    left    = s2_r.col0 ? 1'b0 : held_left_r;
    right   = s2_r.right_ok ? rd_right_r : 1'b0;
    nr      = s2_r.is_free & (rd_old_r | (rd_free_r & (left | right)));
    any_nxt = s2_r.col0 ? nr : (row_any_r | nr);
    result  = s2_r.row0 ? s2_r.start_seen : any_nxt;
  end

  // forwarding from the write in flight
  assign fwd_reach_old   = s2_valid_r && !s2_r.row0 && (s2_r.col == col_r);
  assign fwd_reach_right = s2_valid_r && !s2_r.row0 && (s2_r.col == col_nxt);
  assign fwd_free        = s2_valid_r && (s2_r.col == col_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GW_W'(MAX_WIDTH);
      grid_height_r <= GH_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_ch.data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_ch.data[GH_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters and start mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      start_col_r  <= '0;
      start_seen_r <= 1'b0;
    end else if (in_fire) begin
      if (!last_col) begin
        col_r <= col_nxt;
      end else begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_inc[ROW_W-1:0];
      end
      if (last_col && last_row) begin
        start_col_r  <= '0;
        start_seen_r <= 1'b0;
      end else if (row0 && is_start) begin
        start_col_r  <= col_r;
        start_seen_r <= 1'b1;
      end
    end
  end

  // line memory reads, top row reach comes from the start mark
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (row1) begin
        rd_old_r   <= start_seen_r && (start_col_r == col_r);
        rd_right_r <= start_seen_r && (start_col_r == col_nxt);
      end else begin
        rd_old_r   <= fwd_reach_old ? nr : reach_mem[col_r];
        rd_right_r <= fwd_reach_right ? nr : reach_mem[col_nxt];
      end
      rd_free_r <= fwd_free ? s2_r.is_free : free_mem[col_r];
    end
  end

  // line memory writes
  always_ff @(posedge clk) begin
    if (s2_go) begin
      free_mem[s2_r.col] <= s2_r.is_free;
      if (!s2_r.row0) begin
        reach_mem[s2_r.col] <= nr;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_r.col        <= col_r;
      s2_r.is_free    <= is_free;
      s2_r.row0       <= row0;
      s2_r.col0       <= (col_r == '0);
      s2_r.right_ok   <= !last_col;
      s2_r.grid_end   <= last_col && last_row;
      s2_r.start_seen <= start_seen_r | (row0 && is_start);
    end
  end

  // stage control, row state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      held_left_r <= 1'b0;
      row_any_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_path_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        held_left_r <= s2_r.grid_end ? 1'b0 : rd_old_r;
        if (s2_r.grid_end) begin
          row_any_r <= 1'b0;
        end else if (!s2_r.row0) begin
          row_any_r <= any_nxt;
        end
      end
      if (s2_go && s2_r.grid_end) begin
        out_valid_r <= 1'b1;
        out_path_r  <= result;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- verif/grid_downward_path_reachability_tb.sv -----
`timescale 1ns / 100ps

module grid_downward_path_reachability_tb;
  import gdpr_pkg::*;

  // cell kind and register index that the package leaves unnamed
  localparam logic [KIND_W-1:0]    CELL_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam int unsigned          HOLD_CYCLES = 400;
  localparam int unsigned          CYCLE_LIMIT = 600000;
  localparam int unsigned          MAX_REPORTS = 40;

  // predicts the answer of each grid and checks the result items in order
  class path_scoreboard;
    int unsigned width_reg;
    int unsigned height_reg;
    bit          reach_row [MAX_WIDTH];
    bit          free_row [MAX_WIDTH];
    bit          left_reach;
    bit          start_seen;
    bit          any_reach;
    int unsigned col;
    int unsigned row;
    int unsigned start_col;
    bit          expected_found [$];
    int unsigned errors;
    int unsigned cells;
    int unsigned answers;
    int unsigned found_count;

    function new();
      width_reg  = MAX_WIDTH;
      height_reg = 1;
      foreach (reach_row[i]) begin
        reach_row[i] = 1'b0;
        free_row[i]  = 1'b0;
      end
      clear_grid();
    endfunction

    static function int unsigned fit_dim(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void clear_grid();
      left_reach = 1'b0;
      start_seen = 1'b0;
      any_reach  = 1'b0;
      col        = 0;
      row        = 0;
      start_col  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_GRID_WIDTH) width_reg = 32'(data[GW_W-1:0]);
      else if (idx == REG_GRID_HEIGHT) height_reg = 32'(data[GH_W-1:0]);
    endfunction

    // one accepted cell item
    function void note_cell(logic [KIND_W-1:0] kind);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      bit          open_cell;
      bit          last_col;
      bit          last_row;
      bit          above;
      bit          from_left;
      bit          from_right;
      bit          now_reach;
      w         = fit_dim(width_reg, MAX_WIDTH);
      h         = fit_dim(height_reg, MAX_HEIGHT);
      c         = col;
      open_cell = (kind != CELL_ROCK);
      last_col  = (c + 1 >= w);
      last_row  = (row + 1 >= h);
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      cells++;

      if (row == 0) begin
        // top row: only here a start mark counts, the last one wins
        if (kind == CELL_START) begin
          start_col  = c;
          start_seen = 1'b1;
        end
        free_row[c] = open_cell;
        if (last_col) begin
          foreach (reach_row[i]) reach_row[i] = start_seen && (i == start_col);
          any_reach = start_seen;
        end
      end else begin
        // lower rows: straight down, or diagonal past a free side cell
        if (c == 0) begin
          left_reach = 1'b0;
          any_reach  = 1'b0;
        end
        above      = reach_row[c];
        from_left  = (c > 0) ? left_reach : 1'b0;
        from_right = (c + 1 < w && c + 1 < MAX_WIDTH) ? reach_row[c + 1] : 1'b0;
        now_reach  = open_cell & (above | (free_row[c] & (from_left | from_right)));
        reach_row[c] = now_reach;
        free_row[c]  = open_cell;
        left_reach   = above;
        any_reach    = any_reach | now_reach;
      end

      if (!last_col) begin
        col = c + 1;
        return;
      end
      col = 0;
      if (!last_row) begin
        row++;
        return;
      end
      expected_found.push_back(any_reach);
      clear_grid();
    endfunction

    // one accepted result item
    function void check_found(logic found);
      bit want;
      if (expected_found.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result item, expected none, actual path_found=%0b",
                   $time, found);
        return;
      end
      want = expected_found.pop_front();
      answers++;
      if (found !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: path_found mismatch, expected %0b, actual %0b", $time, want, found);
      end else if (want) begin
        found_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_found.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gdpr_cell_if   cell_bus ();
  gdpr_result_if res_bus ();
  gdpr_cfg_if    cfg_bus ();

  grid_downward_path_reachability u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cell_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  path_scoreboard sb;
  int unsigned    burst_left;
  int unsigned    settings_used;
  int unsigned    input_stalls;
  int unsigned    cycle_count;
  bit             hold_req;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, sb.pending());
      $display("grid_downward_path_reachability verification failed");
      $finish;
    end
  end

  // result monitor and input back-pressure count
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) sb.check_found(res_bus.path_found);
    if (rst_n && cell_bus.valid && !cell_bus.ready) input_stalls++;
  end

  // receiver: rotating stall patterns, plus a long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_timer;
    hold_left  = 0;
    mode       = 0;
    mode_timer = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_timer == 0) begin
        mode       = $urandom_range(0, 3);
        mode_timer = $urandom_range(16, 96);
      end
      mode_timer--;
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= ($urandom_range(0, 99) < 60);
          2: res_bus.ready <= (mode_timer % 3 == 0);
          default: res_bus.ready <= ($urandom_range(0, 99) < 15);
        endcase
      end
    end
  end

  // offer one cell item, in bursts with random gaps between them
  task automatic send_cell(logic [KIND_W-1:0] kind);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        cell_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    end
    cell_bus.valid     <= 1'b1;
    cell_bus.cell_kind <= kind;
    do @(posedge clk); while (!cell_bus.ready);
    sb.note_cell(kind);
    burst_left--;
  endtask

  // register write; valid stays high so back-to-back writes need no dip
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
  endtask

  // stop offering cells until every answer is back and the pipeline is empty
  task automatic wait_drained();
    cell_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // new grid size, written only with the block idle
  task automatic set_dims(int unsigned w, int unsigned h);
    logic [CFG_DATA_W-1:0] w_data;
    wait_drained();
    w_data              = CFG_DATA_W'($urandom);
    w_data[GW_W-1:0]    = w[GW_W-1:0];
    cfg_write(REG_GRID_WIDTH, w_data);
    cfg_write(REG_GRID_HEIGHT, h[GH_W-1:0]);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // directed grid: F free, R rock, S start, X spare kind, rows split by '/'
  task automatic send_pattern(string p);
    byte ch;
    for (int i = 0; i < p.len(); i++) begin
      ch = p.getc(i);
      case (ch)
        "F": send_cell(CELL_FREE);
        "R": send_cell(CELL_ROCK);
        "S": send_cell(CELL_START);
        "X": send_cell(CELL_SPARE);
        default: ;
      endcase
    end
  endtask

  // random cell with mostly one start in the top row and some noise below
  function automatic logic [KIND_W-1:0] pick_kind(int unsigned r, int unsigned c,
                                                  int unsigned start_col,
                                                  int unsigned rock_pct, bit no_start);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (r == 0) begin
      if (!no_start && c == start_col) return CELL_START;
      if (roll < 4) return CELL_START;
      if (roll < 4 + rock_pct) return CELL_ROCK;
      return (roll >= 97) ? CELL_SPARE : CELL_FREE;
    end
    if (roll < rock_pct) return CELL_ROCK;
    if (roll >= 96) return CELL_SPARE;
    if (roll >= 93) return CELL_START;
    return CELL_FREE;
  endfunction

  task automatic send_random_grid(int unsigned w, int unsigned h);
    int unsigned start_col;
    int unsigned rock_pct;
    bit          no_start;
    start_col = $urandom_range(0, w - 1);
    no_start  = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 4))
      0: rock_pct = 0;
      1: rock_pct = 15;
      2: rock_pct = 30;
      3: rock_pct = 50;
      default: rock_pct = 80;
    endcase
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++)
        send_cell(pick_kind(r, c, start_col, rock_pct, no_start));
  endtask

  task automatic run_setting(int unsigned w_val, int unsigned h_val, int unsigned grids);
    int unsigned w;
    int unsigned h;
    set_dims(w_val, h_val);
    w = path_scoreboard::fit_dim(w_val, MAX_WIDTH);
    h = path_scoreboard::fit_dim(h_val, MAX_HEIGHT);
    repeat (grids) send_random_grid(w, h);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned w;
    int unsigned h;
    sb            = new();
    burst_left    = 0;
    settings_used = 0;
    input_stalls  = 0;
    cycle_count   = 0;
    hold_req      = 1'b0;
    rst_n              <= 1'b0;
    cell_bus.valid     <= 1'b0;
    cell_bus.cell_kind <= CELL_FREE;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_GRID_WIDTH;
    cfg_bus.data       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid at the reset size, full width and one row
    send_random_grid(MAX_WIDTH, 1);

    // directed: blocked down, diagonal past a free spare cell, no start,
    // start mark below the top row
    set_dims(2, 2);
    send_pattern("SR/RF");
    send_pattern("XS/FR");
    send_pattern("FF/FF");
    send_pattern("FF/SF");
    // two starts in the top row, the last one is blocked
    set_dims(3, 2);
    send_pattern("SFS/FRR");
    // single row: answer is whether a start appeared
    wait_drained();
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_bus.valid <= 1'b0;
    set_dims(2, 1);
    send_pattern("SF");
    send_pattern("FF");

    // sizes at and past the limits, zero acting as one
    run_setting(0, 0, 20);
    // receiver holds off while one-cell grids keep coming
    set_dims(1, 1);
    hold_req = 1'b1;
    repeat (60) send_random_grid(1, 1);
    run_setting(127, 2, 1);
    run_setting(2, 0, 10);
    run_setting(0, 5, 8);

    // random sizes, mostly small
    random_start = sb.cells;
    while (sb.cells - random_start < 250) begin
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(9, 20);
        h = $urandom_range(1, 6);
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(1, 3);
        h = $urandom_range(8, 24);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      run_setting(w, h, $urandom_range(1, 3));
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d cells in %0d grids over %0d grid sizes, %0d grids with a path",
             sb.cells, sb.answers, settings_used, sb.found_count);
    $display("cell input held back for %0d cycles, longest result hold %0d cycles",
             input_stalls, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grid_downward_path_reachability verification clean");
    end else begin
      $display("grid_downward_path_reachability verification failed");
    end
    $finish;
  end

endmodule
